### rtl/dos_pkg.sv
// ----------------------------------------------------------------------------
// dos_pkg
// Shared types and constants for the DHCP option scanner.
// ----------------------------------------------------------------------------
package dos_pkg;

  localparam int DEFAULT_MAX_REGION_BYTES = 2048;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int OFFSET_W = 11;

  localparam logic [BYTE_W-1:0] TARGET_CODE_RESET = 8'd53;
  localparam logic [BYTE_W-1:0] CODE_PAD          = 8'd0;
  localparam logic [BYTE_W-1:0] CODE_END          = 8'd255;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND  = 3'd0,
    ST_END    = 3'd1,
    ST_ABSENT = 3'd2,
    ST_TRUNC  = 3'd3,
    ST_SHORT  = 3'd4,
    ST_LONG   = 3'd5
  } status_t;

  typedef struct packed {
    logic                value_valid;
    logic [BYTE_W-1:0]   value_byte;
    logic                verdict_valid;
    status_t             status;
    logic [OFFSET_W-1:0] option_offset;
    logic [BYTE_W-1:0]   option_length;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] option_byte;
    logic              last_byte;
  } in_item_t;

endpackage

### rtl/dos_in_stage.sv
// ----------------------------------------------------------------------------
// dos_in_stage
// Input register: captures one byte per transfer and holds it until the
// parse engine consumes it.
// ----------------------------------------------------------------------------
module dos_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dos_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              step,
  output dos_pkg::in_item_t held_item
);
  import dos_pkg::*;

  logic held_valid;

  assign in_ready = !held_valid || advance;
  assign step     = held_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

### rtl/dos_parse_engine.sv
// ----------------------------------------------------------------------------
// dos_parse_engine
// Option record walker: phase and counter state, target code register and
// the per-byte result.
// ----------------------------------------------------------------------------
module dos_parse_engine #(
  parameter int MAX_REGION_BYTES = dos_pkg::DEFAULT_MAX_REGION_BYTES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [dos_pkg::BYTE_W-1:0] cfg_wr_data,
  input  logic                      step,
  input  dos_pkg::in_item_t         item,
  output logic                      res_valid,
  output dos_pkg::result_t          res
);
  import dos_pkg::*;

  localparam int POS_W = $clog2(MAX_REGION_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_REGION_BYTES);

  typedef enum logic [2:0] {
    PH_CODE      = 3'd0,
    PH_MATCH_LEN = 3'd1,
    PH_VALUE     = 3'd2,
    PH_SKIP_LEN  = 3'd3,
    PH_SKIP_BODY = 3'd4
  } phase_t;

  logic [BYTE_W-1:0]   target_code;
  phase_t              phase, phase_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [BYTE_W-1:0]   skip_remaining, skip_remaining_next;
  logic [OFFSET_W-1:0] match_offset, match_offset_next;
  logic [BYTE_W-1:0]   match_length, match_length_next;
  logic                search_done, search_done_next;

  logic [BYTE_W-1:0] b;
  logic              last;
  logic              verd, with_match;
  logic [BYTE_W-1:0] skip_dec;

  assign b        = item.option_byte;
  assign last     = item.last_byte;
  assign skip_dec = skip_remaining - 1'b1;

  always_comb begin
    phase_next          = phase;
    pos_next            = pos;
    skip_remaining_next = skip_remaining;
    match_offset_next   = match_offset;
    match_length_next   = match_length;
    search_done_next    = search_done;
    verd                = 1'b0;
    with_match          = 1'b0;
    res                 = '0;
    res.status          = ST_FOUND;

    if (search_done) begin
      // ignore bytes until region end
    end else if (pos >= POS_MAX) begin
      verd       = 1'b1;
      res.status = ST_LONG;
    end else begin
      pos_next = pos + 1'b1;
      if (pos == '0 && last) begin
        verd       = 1'b1;
        res.status = ST_SHORT;
      end else begin
        case (phase)
          PH_CODE: begin
            if (b == CODE_PAD) begin
            end else if (b == CODE_END) begin
              verd       = 1'b1;
              res.status = ST_END;
            end else if (b == target_code) begin
              match_offset_next = OFFSET_W'(pos);
              match_length_next = '0;
              phase_next        = PH_MATCH_LEN;
              if (last) begin
                verd       = 1'b1;
                with_match = 1'b1;
                res.status = ST_TRUNC;
              end
            end else begin
              phase_next = PH_SKIP_LEN;
            end
          end
          PH_MATCH_LEN: begin
            match_length_next = b;
            if (last) begin
              verd       = 1'b1;
              with_match = 1'b1;
              res.status = ST_TRUNC;
            end else if (b == '0) begin
              verd       = 1'b1;
              with_match = 1'b1;
              res.status = ST_FOUND;
            end else begin
              skip_remaining_next = b;
              phase_next          = PH_VALUE;
            end
          end
          PH_VALUE: begin
            res.value_valid     = 1'b1;
            res.value_byte      = b;
            skip_remaining_next = skip_dec;
            if (skip_dec == '0) begin
              verd       = 1'b1;
              with_match = 1'b1;
              res.status = ST_FOUND;
            end else if (last) begin
              verd       = 1'b1;
              with_match = 1'b1;
              res.status = ST_TRUNC;
            end
          end
          PH_SKIP_LEN: begin
            skip_remaining_next = b;
            phase_next          = (b != '0) ? PH_SKIP_BODY : PH_CODE;
          end
          PH_SKIP_BODY: begin
            skip_remaining_next = skip_dec;
            if (skip_dec == '0) begin
              phase_next = PH_CODE;
            end
          end
          default: begin
            phase_next = PH_CODE;
          end
        endcase
        if (!verd && last) begin
          verd       = 1'b1;
          res.status = ST_ABSENT;
        end
      end
    end

    if (verd) begin
      search_done_next = 1'b1;
    end
    if (with_match) begin
      res.option_offset = match_offset_next;
      res.option_length = match_length_next;
    end
    res.verdict_valid = verd;
    if (!verd) begin
      res.status = ST_FOUND;
    end

    if (last) begin
      phase_next          = PH_CODE;
      pos_next            = '0;
      skip_remaining_next = '0;
      match_offset_next   = '0;
      match_length_next   = '0;
      search_done_next    = 1'b0;
    end
  end

  assign res_valid = res.value_valid || res.verdict_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_code    <= TARGET_CODE_RESET;
      phase          <= PH_CODE;
      pos            <= '0;
      skip_remaining <= '0;
      match_offset   <= '0;
      match_length   <= '0;
      search_done    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_code <= cfg_wr_data;
      end
      if (step) begin
        phase          <= phase_next;
        pos            <= pos_next;
        skip_remaining <= skip_remaining_next;
        match_offset   <= match_offset_next;
        match_length   <= match_length_next;
        search_done    <= search_done_next;
      end
    end
  end

  a_rearm_on_last: assert property (@(posedge clk) disable iff (rst)
    step && last |=> pos == '0 && !search_done && phase == PH_CODE)
    else $error("state not rearmed after region end");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_MAX)
    else $error("byte position past region bound");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    step && search_done && !last |=> search_done)
    else $error("search_done dropped inside a region");

  // a found value leaves the phase at value with a zero count until region end
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    !search_done && (phase == PH_VALUE || phase == PH_SKIP_BODY) |->
      skip_remaining != '0)
    else $error("body count zero in body phase");

endmodule

### rtl/dos_out_stage.sv
// ----------------------------------------------------------------------------
// dos_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module dos_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dos_pkg::result_t load_res,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output dos_pkg::result_t out_res
);
  import dos_pkg::*;

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

### rtl/dhcp_option_scanner_core.sv
// ----------------------------------------------------------------------------
// dhcp_option_scanner_core
// Scans a DHCP options region, one byte per transfer, for the option whose
// code is held in target_code.
//
// Input channel (in_valid/in_ready): option_byte plus last_byte marking the
// final byte of the region. Output channel (out_valid/out_ready): a value
// byte of the matched option and/or one verdict per region (status, offset
// and length of the match). Bytes that cause no result produce no transfer.
// Configuration: cfg_wr_en/cfg_wr_data write target_code; the user must
// write it only while idle, the block does not enforce it. Throughput: one
// byte per cycle unless out_ready stalls the result register; the parse
// engine sits combinationally between the input register and the result
// register, which loads each result as its byte leaves the input register.
// When out_ready is low the result register holds and the input register
// fills, then in_ready drops; no result is lost.
// Reset (rst, synchronous): clears valids and parse state, target_code = 53.
// ----------------------------------------------------------------------------
module dhcp_option_scanner_core #(
  parameter int MAX_REGION_BYTES = dos_pkg::DEFAULT_MAX_REGION_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [dos_pkg::BYTE_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dos_pkg::BYTE_W-1:0]    option_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          value_valid,
  output logic [dos_pkg::BYTE_W-1:0]    value_byte,
  output logic                          verdict_valid,
  output logic [dos_pkg::STATUS_W-1:0]  status,
  output logic [dos_pkg::OFFSET_W-1:0]  option_offset,
  output logic [dos_pkg::BYTE_W-1:0]    option_length
);
  import dos_pkg::*;

  in_item_t in_item, held_item;
  result_t  res, out_res;
  logic     advance, step, res_valid;

  assign in_item.option_byte = option_byte;
  assign in_item.last_byte   = last_byte;

  dos_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .advance   (advance),
    .step      (step),
    .held_item (held_item)
  );

  dos_parse_engine #(
    .MAX_REGION_BYTES (MAX_REGION_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (held_item),
    .res_valid   (res_valid),
    .res         (res)
  );

  dos_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .load_res  (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign value_valid   = out_res.value_valid;
  assign value_byte    = out_res.value_byte;
  assign verdict_valid = out_res.verdict_valid;
  assign status        = out_res.status;
  assign option_offset = out_res.option_offset;
  assign option_length = out_res.option_length;

endmodule
